// ----- design/online_bin_packing_allocator_macros.svh -----
`ifndef ONLINE_BIN_PACKING_ALLOCATOR_MACROS_SVH
`define ONLINE_BIN_PACKING_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define OBPA_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OBPA_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/obpa_pkg.sv -----
package obpa_pkg;

	localparam int NUM_BINS  = 64;
	localparam int SIZE_BITS = 16;

	localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam int CNT_W = $clog2(NUM_BINS + 1);

	// port widths fixed by the interface
	localparam int ITEM_SIZE_W = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int BIN_INDEX_W = 6;
	localparam int BINS_USED_W = 7;

	localparam logic [1:0] MODE_FIRST = 2'd0;
	localparam logic [1:0] MODE_NEXT  = 2'd1;
	localparam logic [1:0] MODE_BEST  = 2'd2;

	localparam logic [1:0] STATUS_PLACED   = 2'd0;
	localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
	localparam logic [1:0] STATUS_OVERSIZE = 2'd2;
	localparam logic [1:0] STATUS_CLEARED  = 2'd3;

	localparam logic CMD_PLACE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic REG_FIT_MODE     = 1'b0;
	localparam logic REG_BIN_CAPACITY = 1'b1;

endpackage

// ----- design/obpa_ram.sv -----
module obpa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- design/online_bin_packing_allocator.sv -----
// Online bin-packing allocator with first fit, next fit and best fit policies. Each
// transaction on the input channel either places one item or clears all bins, and gives
// exactly one result. Clear, oversize items and next fit with the pointer past the last
// bin go straight from idle to the finish state with no scan. A placement scans the fill
// memory one bin per cycle from the start bin (0, or the next-fit pointer) up to the first
// empty bin, at most NUM_BINS bins; first and next fit stop at the first bin that fits. The
// single fill memory read port sets this scan rate. A result still waiting in the output
// register holds the block in its last state. Bins at or above the used count read as
// empty, so clear and reset take effect at once with no clearing pass. A new item is taken
// once the previous one has its result in the output register. Configuration writes must
// happen while no item is in flight.
`include "online_bin_packing_allocator_macros.svh"

module online_bin_packing_allocator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [obpa_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   command,
	input  logic [obpa_pkg::ITEM_SIZE_W-1:0]       item_size,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [1:0]                             status,
	output logic [obpa_pkg::BIN_INDEX_W-1:0]       bin_index,
	output logic [obpa_pkg::BINS_USED_W-1:0]       bins_used
);

	localparam int SIZE_W = obpa_pkg::SIZE_BITS;
	localparam int IDX_W  = obpa_pkg::IDX_W;
	localparam int CNT_W  = obpa_pkg::CNT_W;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

	state_t             state_q;
	logic [1:0]         fit_mode_q;
	logic [SIZE_W-1:0]  cap_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   ptr_q;
	logic [SIZE_W-1:0]  size_q;
	logic [IDX_W-1:0]   scan_addr_q;
	logic [IDX_W-1:0]   last_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               found_q;
	logic [IDX_W-1:0]   pick_q;
	logic [SIZE_W-1:0]  best_left_q;
	logic [SIZE_W-1:0]  new_fill_q;
	logic [1:0]         res_status_q;
	logic               out_valid_q;
	logic [1:0]         status_q;
	logic [obpa_pkg::BIN_INDEX_W-1:0] bin_index_q;
	logic [obpa_pkg::BINS_USED_W-1:0] bins_used_q;

	logic [SIZE_W-1:0]  size_in;
	logic               in_fire;
	logic [IDX_W-1:0]   last_in;
	logic [SIZE_W-1:0]  rd_data;
	logic [SIZE_W-1:0]  fill_eff;
	logic [SIZE_W:0]    sum;
	logic               fits;
	logic [SIZE_W-1:0]  left;
	logic               is_best;
	logic               hit;
	logic               eval_done;
	logic               fin_fire;
	logic               ram_we;
	logic [CNT_W-1:0]   count_after;

	assign size_in  = SIZE_W'(item_size);
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign last_in  = (count_q < CNT_W'(obpa_pkg::NUM_BINS)) ? count_q[IDX_W-1:0]
		: IDX_W'(obpa_pkg::NUM_BINS - 1);

	// bins at or above the used count are empty whatever the memory holds
	assign fill_eff = (CNT_W'(idx_s1) < count_q) ? rd_data : '0;
	assign sum      = {1'b0, fill_eff} + {1'b0, size_q};
	assign fits     = (sum <= {1'b0, cap_q});
	assign left     = cap_q - sum[SIZE_W-1:0];
	assign is_best  = (fit_mode_q == obpa_pkg::MODE_BEST);
	assign hit      = is_best ? (fits && (!found_q || left < best_left_q)) : fits;
	assign eval_done = rd_vld_s1 && ((!is_best && fits) || idx_s1 == last_q);

	assign fin_fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	assign ram_we   = fin_fire && (res_status_q == obpa_pkg::STATUS_PLACED);

	always_comb begin
		count_after = count_q;
		if (res_status_q == obpa_pkg::STATUS_CLEARED) begin
			count_after = '0;
		end else if (res_status_q == obpa_pkg::STATUS_PLACED &&
			CNT_W'(pick_q) >= count_q) begin
			count_after = CNT_W'(pick_q) + CNT_W'(1);
		end
	end

	obpa_ram #(
		.WIDTH(SIZE_W),
		.DEPTH(obpa_pkg::NUM_BINS)
	) u_fill_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pick_q),
		.wdata(new_fill_q),
		.re   (state_q == ST_SCAN),
		.raddr(scan_addr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fit_mode_q   <= obpa_pkg::MODE_FIRST;
			cap_q        <= SIZE_W'(16'hFFFF);
			count_q      <= '0;
			ptr_q        <= '0;
			size_q       <= '0;
			scan_addr_q  <= '0;
			last_q       <= '0;
			rd_vld_s1    <= 1'b0;
			idx_s1       <= '0;
			found_q      <= 1'b0;
			pick_q       <= '0;
			best_left_q  <= '0;
			new_fill_q   <= '0;
			res_status_q <= obpa_pkg::STATUS_PLACED;
			out_valid_q  <= 1'b0;
			status_q     <= obpa_pkg::STATUS_PLACED;
			bin_index_q  <= '0;
			bins_used_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					obpa_pkg::REG_FIT_MODE:     fit_mode_q <= cfg_data[1:0];
					obpa_pkg::REG_BIN_CAPACITY: cap_q      <= SIZE_W'(cfg_data);
					default: ;
				endcase
			end

			// a new result loaded in the same cycle keeps valid high
			if (out_valid_q && out_ready && !fin_fire) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_fire) begin
						found_q <= 1'b0;
						size_q  <= size_in;
						last_q  <= last_in;
						scan_addr_q <= (fit_mode_q == obpa_pkg::MODE_NEXT)
							? ptr_q[IDX_W-1:0] : '0;
						if (command == obpa_pkg::CMD_CLEAR) begin
							res_status_q <= obpa_pkg::STATUS_CLEARED;
							state_q      <= ST_FIN;
						end else if (size_in > cap_q) begin
							res_status_q <= obpa_pkg::STATUS_OVERSIZE;
							state_q      <= ST_FIN;
						end else if (fit_mode_q == obpa_pkg::MODE_NEXT &&
							ptr_q == CNT_W'(obpa_pkg::NUM_BINS)) begin
							// next fit already ran off the end
							res_status_q <= obpa_pkg::STATUS_NO_FIT;
							state_q      <= ST_FIN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= !eval_done;
					idx_s1    <= scan_addr_q;
					if (scan_addr_q != last_q) begin
						scan_addr_q <= scan_addr_q + IDX_W'(1);
					end
					if (rd_vld_s1 && hit) begin
						found_q     <= 1'b1;
						pick_q      <= idx_s1;
						best_left_q <= left;
						new_fill_q  <= sum[SIZE_W-1:0];
					end
					if (eval_done) begin
						res_status_q <= (found_q || hit) ? obpa_pkg::STATUS_PLACED
							: obpa_pkg::STATUS_NO_FIT;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						bin_index_q <= (res_status_q == obpa_pkg::STATUS_PLACED)
							? obpa_pkg::BIN_INDEX_W'(pick_q) : '0;
						bins_used_q <= obpa_pkg::BINS_USED_W'(count_after);
						count_q     <= count_after;
						if (res_status_q == obpa_pkg::STATUS_CLEARED) begin
							ptr_q <= '0;
						end else if (fit_mode_q == obpa_pkg::MODE_NEXT) begin
							if (res_status_q == obpa_pkg::STATUS_PLACED) begin
								ptr_q <= CNT_W'(pick_q);
							end else if (res_status_q == obpa_pkg::STATUS_NO_FIT) begin
								ptr_q <= CNT_W'(obpa_pkg::NUM_BINS);
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bin_index = bin_index_q;
	assign bins_used = bins_used_q;

	`OBPA_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(obpa_pkg::NUM_BINS),
		"used bin count beyond number of bins")
	`OBPA_ASSERT_IMP(a_ptr_range, 1'b1,
		ptr_q <= count_q || ptr_q == CNT_W'(obpa_pkg::NUM_BINS),
		"next fit pointer skipped an unused bin")
	`OBPA_ASSERT_IMP(a_scan_bound, rd_vld_s1, idx_s1 <= last_q && state_q == ST_SCAN,
		"scan read past the last candidate bin")
	`OBPA_ASSERT_NXT(a_write_in_used, ram_we, CNT_W'(pick_q) < count_q,
		"fill written to a bin not counted as used")
	`OBPA_ASSERT_IMP(a_placed_index, out_valid_q && status_q == obpa_pkg::STATUS_PLACED,
		obpa_pkg::BINS_USED_W'(bin_index_q) < bins_used_q || obpa_pkg::NUM_BINS > 64,
		"placed bin index not below used count")

endmodule

// ----- bench/online_bin_packing_allocator_checker.sv -----
`timescale 1ns / 1ps

module online_bin_packing_allocator_checker
	import obpa_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   command,
	input  logic [ITEM_SIZE_W-1:0] item_size,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [1:0]             status,
	input  logic [BIN_INDEX_W-1:0] bin_index,
	input  logic [BINS_USED_W-1:0] bins_used,
	output int                     errors,
	output int                     outstanding
);

	typedef struct packed {
		logic [1:0]             status;
		logic [BIN_INDEX_W-1:0] bin_index;
		logic [BINS_USED_W-1:0] bins_used;
	} alloc_result_t;

	logic [SIZE_BITS-1:0] fill [NUM_BINS];
	logic [CNT_W-1:0]     used_count;
	logic [CNT_W-1:0]     nf_ptr;
	logic [1:0]           mode;
	logic [SIZE_BITS-1:0] capacity;
	alloc_result_t        expected_allocs[$];
	alloc_result_t        want;
	int                   mismatches;

	assign errors = mismatches;

	function automatic logic has_room(int b, logic [SIZE_BITS-1:0] size);
		return ({1'b0, fill[b]} + {1'b0, size}) <= {1'b0, capacity};
	endfunction

	// updates the bin state for one transaction and returns the result it must give
	function automatic alloc_result_t allocate(logic cmd, logic [SIZE_BITS-1:0] size);
		alloc_result_t r;
		int b;
		int pick;
		int last;
		logic found;
		logic [SIZE_BITS:0] left;
		logic [SIZE_BITS:0] best_left;
		r = '0;
		pick = 0;
		found = 1'b0;
		best_left = '0;
		if (cmd == CMD_CLEAR) begin
			for (b = 0; b < NUM_BINS; b++)
				fill[b] = '0;
			used_count = '0;
			nf_ptr = '0;
			r.status = STATUS_CLEARED;
			return r;
		end
		r.bins_used = BINS_USED_W'(used_count);
		if (size > capacity) begin
			r.status = STATUS_OVERSIZE;
			return r;
		end
		case (mode)
			MODE_NEXT: begin
				// pointer only moves forward, and runs past the last bin on a miss
				while (nf_ptr < NUM_BINS && !found) begin
					if (has_room(nf_ptr, size)) begin
						pick = nf_ptr;
						found = 1'b1;
					end else begin
						nf_ptr = nf_ptr + 1'b1;
					end
				end
			end
			MODE_BEST: begin
				// used bins plus the first empty one
				last = (used_count < NUM_BINS) ? int'(used_count) : NUM_BINS - 1;
				for (b = 0; b <= last; b++) begin
					if (has_room(b, size)) begin
						left = {1'b0, capacity} - fill[b] - size;
						if (!found || left < best_left) begin
							found = 1'b1;
							best_left = left;
							pick = b;
						end
					end
				end
			end
			default: begin
				for (b = 0; b < NUM_BINS && !found; b++) begin
					if (has_room(b, size)) begin
						pick = b;
						found = 1'b1;
					end
				end
			end
		endcase
		if (!found) begin
			r.status = STATUS_NO_FIT;
			return r;
		end
		fill[pick] = fill[pick] + size;
		if (pick >= used_count)
			used_count = CNT_W'(pick + 1);
		r.status = STATUS_PLACED;
		r.bin_index = BIN_INDEX_W'(pick);
		r.bins_used = BINS_USED_W'(used_count);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BINS; b++)
				fill[b] = '0;
			used_count = '0;
			nf_ptr = '0;
			mode = MODE_FIRST;
			capacity = '1;
			mismatches = 0;
			expected_allocs.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_allocs.size() == 0) begin
					$error("result with no transaction pending: status %0d bin_index %0d bins_used %0d",
						status, bin_index, bins_used);
					mismatches++;
				end else begin
					want = expected_allocs.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (bin_index !== want.bin_index) begin
						$error("bin_index: expected %0d, got %0d", want.bin_index, bin_index);
						mismatches++;
					end
					if (bins_used !== want.bins_used) begin
						$error("bins_used: expected %0d, got %0d", want.bins_used, bins_used);
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_allocs.push_back(allocate(command, item_size));
			if (cfg_we) begin
				if (cfg_index == REG_FIT_MODE)
					mode = cfg_data[1:0];
				else
					capacity = cfg_data[SIZE_BITS-1:0];
			end
			outstanding <= expected_allocs.size();
		end
	end

endmodule

// ----- bench/online_bin_packing_allocator_tb.sv -----
`timescale 1ns / 1ps

module online_bin_packing_allocator_tb;
	import obpa_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int         HOLD_OFF_CYCLES = 300;
	localparam int         DRAIN_CYCLES = NUM_BINS + 6;
	localparam int         PHASES = 12;
	localparam int         PHASE_ITEMS = 130;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   command;
	logic [ITEM_SIZE_W-1:0] item_size;
	logic                   out_valid;
	logic                   out_ready;
	logic [1:0]             status;
	logic [BIN_INDEX_W-1:0] bin_index;
	logic [BINS_USED_W-1:0] bins_used;
	int                     errors;
	int                     outstanding;

	int   send_gap_pct;
	int   recv_gap_pct;
	int   cur_cap;
	int   hold_req;

	online_bin_packing_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.item_size (item_size),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.bin_index (bin_index),
		.bins_used (bins_used)
	);

	online_bin_packing_allocator_checker alloc_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.item_size   (item_size),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.bin_index   (bin_index),
		.bins_used   (bins_used),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("online_bin_packing_allocator_tb NOT OK");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		int holds_done;
		holds_done = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != holds_done) begin
				holds_done++;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	task automatic offer(input logic cmd, input logic [ITEM_SIZE_W-1:0] size);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		item_size <= size;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// both registers, back to back, only once every result is out
	task automatic configure(input logic [1:0] mode, input int cap);
		settle();
		cfg_we <= 1'b1;
		cfg_index <= REG_FIT_MODE;
		cfg_data <= {(CFG_DATA_W - 2)'($urandom()), mode};
		@(posedge clk);
		cfg_index <= REG_BIN_CAPACITY;
		cfg_data <= CFG_DATA_W'(cap);
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_cap = cap;
	endtask

	function automatic void pick_item(input int clear_pct, output logic cmd,
			output logic [ITEM_SIZE_W-1:0] size);
		int r;
		r = $urandom_range(99);
		cmd = CMD_PLACE;
		size = ITEM_SIZE_W'($urandom_range(cur_cap / 3));
		if (r < clear_pct) begin
			cmd = CMD_CLEAR;
			size = ITEM_SIZE_W'($urandom());
		end else if (r < clear_pct + 4) begin
			size = (cur_cap < 65535) ? ITEM_SIZE_W'($urandom_range(65535, cur_cap + 1))
				: ITEM_SIZE_W'($urandom());
		end else if (r < clear_pct + 8) begin
			size = '0;
		end else if (r < clear_pct + 12) begin
			size = ITEM_SIZE_W'(cur_cap);
		end else if (r < clear_pct + 18) begin
			size = ITEM_SIZE_W'($urandom());
		end else if (r < 60) begin
			size = ITEM_SIZE_W'($urandom_range(cur_cap, cur_cap / 2));
		end
	endfunction

	initial begin
		logic [1:0]             mode_plan [4];
		logic                   cmd;
		logic [ITEM_SIZE_W-1:0] size;
		int                     cap;
		mode_plan = '{MODE_FIRST, MODE_NEXT, MODE_BEST, MODE_SPARE};
		hold_req = 0;
		send_gap_pct = 15;
		recv_gap_pct = 78;
		cur_cap = 65535;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_FIT_MODE;
		cfg_data <= '0;
		in_valid <= 1'b0;
		command <= CMD_PLACE;
		item_size <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first fit, full capacity
		offer(CMD_PLACE, 16'h0000);
		offer(CMD_PLACE, 16'hFFFF);
		offer(CMD_PLACE, 16'h0000);
		offer(CMD_PLACE, 16'h0001);
		offer(CMD_CLEAR, 16'hFFFF);

		configure(MODE_NEXT, 100);
		offer(CMD_PLACE, 16'd101);
		offer(CMD_PLACE, 16'd100);
		offer(CMD_PLACE, 16'd60);
		offer(CMD_PLACE, 16'd50);
		offer(CMD_PLACE, 16'd40);
		offer(CMD_PLACE, 16'd10);

		configure(MODE_BEST, 100);
		offer(CMD_PLACE, 16'd30);
		offer(CMD_PLACE, 16'd10);
		offer(CMD_PLACE, 16'd5);
		offer(CMD_PLACE, 16'd0);

		// capacity now below the fill of the older bins
		configure(MODE_FIRST, 50);
		offer(CMD_PLACE, 16'd50);
		offer(CMD_PLACE, 16'd0);
		offer(CMD_PLACE, 16'd1);

		configure(MODE_SPARE, 1);
		offer(CMD_PLACE, 16'd1);
		offer(CMD_PLACE, 16'd2);
		offer(CMD_PLACE, 16'd0);

		configure(MODE_NEXT, 1);
		offer(CMD_PLACE, 16'd0);
		offer(CMD_PLACE, 16'd1);
		offer(CMD_CLEAR, 16'h0000);

		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES / 3) begin
				send_gap_pct = 78;
				recv_gap_pct = 15;
			end else if (p == 2 * PHASES / 3) begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
			if (p == 5)
				cap = 1;
			else if (p % 3 == 0)
				cap = 65535;
			else if (p % 3 == 1)
				cap = $urandom_range(40, 2);
			else
				cap = $urandom_range(65534, 41);
			// no clear between phases, so fills carry over into the new setting
			configure(mode_plan[(p + p / 4) % 4], cap);
			if (p == 1 || p == 9)
				hold_req++;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				// odd phases never clear so bins run out
				pick_item((p % 2 == 1) ? 0 : 2, cmd, size);
				offer(cmd, size);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("online_bin_packing_allocator_tb OK");
		else
			$display("online_bin_packing_allocator_tb NOT OK");
		$finish;
	end

endmodule
